// File: rtl/sas_pkg.sv
// sas_pkg: transaction types and fixed conversion constants for the
// sensor averaging and scaling block
// no dependencies
package sas_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 4;
    localparam int PRES_W   = 10;
    localparam int TMAG_W   = 9;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pressure_sample;
        logic [SAMPLE_W-1:0] temperature_sample;
    } t_in_item;

    typedef struct packed {
        logic [PRES_W-1:0] pressure_tenths_kpa;
        logic [TMAG_W-1:0] temperature_magnitude;
        logic              temperature_negative;
    } t_out_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pressure_avg;
        logic [SAMPLE_W-1:0] temperature_avg;
    } t_avg_pair;

    // converter range limit and temperature zero point
    localparam logic [SAMPLE_W-1:0] ADC_LIMIT = 12'd3685;
    localparam logic [SAMPLE_W-1:0] T_SPLIT   = 12'd921;

    // pressure numerator (avg + offset) * mul, divided by 737
    localparam int P_NUM_W = 19;
    localparam logic [P_NUM_W-1:0] P_OFFSET = 19'd11055;
    localparam logic [P_NUM_W-1:0] P_MUL    = 19'd30;
    localparam longint unsigned P_DIV = 64'd737;
    localparam int P_SHIFT   = 29;
    localparam int P_RECIP_W = 20;
    localparam longint unsigned P_RECIP_L = ((64'd1 << P_SHIFT) + P_DIV - 64'd1) / P_DIV;
    localparam logic [P_RECIP_W-1:0] P_RECIP = P_RECIP_W'(P_RECIP_L);

    // temperature numerator diff * mul, divided by 3685
    localparam int T_NUM_W = 21;
    localparam logic [T_NUM_W-1:0] T_MUL = 21'd400;
    localparam longint unsigned T_DIV = 64'd3685;
    localparam int T_SHIFT   = 33;
    localparam int T_RECIP_W = 22;
    localparam longint unsigned T_RECIP_L = ((64'd1 << T_SHIFT) + T_DIV - 64'd1) / T_DIV;
    localparam logic [T_RECIP_W-1:0] T_RECIP = T_RECIP_W'(T_RECIP_L);

    localparam logic [PRES_W-1:0] P_CLAMP = 10'd600;
    localparam logic [TMAG_W-1:0] T_CLAMP = 9'd300;

endpackage

// File: rtl/sas_accum.sv
// sas_accum: per-channel sample accumulation and block averaging
// depends on sas_pkg
module sas_accum #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sas_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_avg_valid,
    output sas_pkg::t_avg_pair  o_avg,
    input  logic                i_avg_stall
);
    import sas_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);
    localparam int AVG_SHIFT = SUM_W + CNT_W + 1;
    localparam int PROD_W    = SUM_W + AVG_SHIFT;
    localparam longint unsigned AVG_RECIP_L =
        ((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
    localparam logic [AVG_SHIFT-1:0] AVG_RECIP = AVG_SHIFT'(AVG_RECIP_L);

    logic [SUM_W-1:0]  r_sum_p, r_sum_t;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_blk_valid;
    logic [SUM_W-1:0]  r_blk_p, r_blk_t;
    logic              r_avg_valid;
    t_avg_pair         r_avg;

    logic [SUM_W-1:0]  n_sum_p, n_sum_t;
    logic              accept, last, blk_ready, avg_ready;
    logic [PROD_W-1:0] prod_p, prod_t;

    assign avg_ready  = !r_avg_valid || !i_avg_stall;
    assign blk_ready  = !r_blk_valid || avg_ready;
    assign o_in_stall = !blk_ready;
    assign accept     = i_in_valid && blk_ready;
    assign last       = (r_cnt == LAST_CNT);

    assign n_sum_p = r_sum_p + SUM_W'(i_in_item.pressure_sample);
    assign n_sum_t = r_sum_t + SUM_W'(i_in_item.temperature_sample);

    // divide by the block length through a reciprocal multiply
    assign prod_p = PROD_W'(r_blk_p) * PROD_W'(AVG_RECIP);
    assign prod_t = PROD_W'(r_blk_t) * PROD_W'(AVG_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_p     <= '0;
            r_sum_t     <= '0;
            r_cnt       <= '0;
            r_blk_valid <= 1'b0;
            r_avg_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (last) begin
                    r_sum_p <= '0;
                    r_sum_t <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_sum_p <= n_sum_p;
                    r_sum_t <= n_sum_t;
                    r_cnt   <= r_cnt + 1'b1;
                end
            end
            if (blk_ready) begin
                r_blk_valid <= accept && last;
            end
            if (avg_ready) begin
                r_avg_valid <= r_blk_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_blk_p <= n_sum_p;
            r_blk_t <= n_sum_t;
        end
        if (r_blk_valid && avg_ready) begin
            r_avg.pressure_avg    <= prod_p[AVG_SHIFT +: SAMPLE_W];
            r_avg.temperature_avg <= prod_t[AVG_SHIFT +: SAMPLE_W];
        end
    end

    assign o_avg_valid = r_avg_valid;
    assign o_avg       = r_avg;

endmodule

// File: rtl/sas_scale.sv
// sas_scale: maps block averages to pressure and signed temperature units,
// holds the temperature sign and the result register
// depends on sas_pkg
module sas_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avg_valid,
    input  sas_pkg::t_avg_pair  i_avg,
    output logic                o_avg_stall,
    output logic                o_out_valid,
    output sas_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);
    import sas_pkg::*;

    localparam int P_PROD_W = P_NUM_W + P_RECIP_W;
    localparam int T_PROD_W = T_NUM_W + T_RECIP_W;

    logic               r_num_valid;
    logic [P_NUM_W-1:0] r_p_num;
    logic [T_NUM_W-1:0] r_t_num;
    logic               r_p_clamp, r_t_clamp, r_t_neg;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               r_sign;

    logic                num_ready, out_ready, t_below, neg;
    logic [SAMPLE_W-1:0] t_diff;
    logic [P_PROD_W-1:0] p_prod;
    logic [T_PROD_W-1:0] t_prod;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign num_ready   = !r_num_valid || out_ready;
    assign o_avg_stall = !num_ready;

    assign t_below = (i_avg.temperature_avg < T_SPLIT);
    assign t_diff  = t_below ? (T_SPLIT - i_avg.temperature_avg)
                             : (i_avg.temperature_avg - T_SPLIT);

    // constant divides through reciprocal multiplies
    assign p_prod = P_PROD_W'(r_p_num) * P_PROD_W'(P_RECIP);
    assign t_prod = T_PROD_W'(r_t_num) * T_PROD_W'(T_RECIP);
    assign neg    = r_t_clamp ? r_sign : r_t_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_sign      <= 1'b0;
        end else begin
            if (num_ready) begin
                r_num_valid <= i_avg_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_num_valid;
            end
            if (r_num_valid && out_ready) begin
                r_sign <= neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_avg_valid && num_ready) begin
            r_p_num   <= (P_NUM_W'(i_avg.pressure_avg) + P_OFFSET) * P_MUL;
            r_t_num   <= T_NUM_W'(t_diff) * T_MUL;
            r_p_clamp <= (i_avg.pressure_avg > ADC_LIMIT);
            r_t_clamp <= (i_avg.temperature_avg > ADC_LIMIT);
            r_t_neg   <= t_below;
        end
        if (r_num_valid && out_ready) begin
            r_out.pressure_tenths_kpa   <= r_p_clamp ? P_CLAMP : p_prod[P_SHIFT +: PRES_W];
            r_out.temperature_magnitude <= r_t_clamp ? T_CLAMP : t_prod[T_SHIFT +: TMAG_W];
            r_out.temperature_negative  <= neg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/sensor_average_and_scale.sv
// sensor_average_and_scale: top level, accumulator and scaling pipeline
// depends on sas_pkg, sas_accum, sas_scale
//
// usage
// input channel: one pressure/temperature sample pair per transaction,
//   accepted when i_in_valid is high and o_in_stall is low
// output channel: one converted result per completed block of
//   SAMPLES_PER_AVERAGE pairs, taken when o_out_valid is high and
//   i_out_stall is low; incomplete blocks give nothing
// throughput: one pair per cycle while o_in_stall is low
// path: from the edge that accepts the last pair of a block, the result is
//   registered in turn as block sum, average multiply, numerator, quotient
// reset: synchronous, active low; clears sums, pair count, held sign and
//   all pipeline valids, so the first block starts fresh
// stall: a stalled result holds; the pipeline stages behind it keep
//   filling, and o_in_stall rises only once every stage holds a result
module sensor_average_and_scale #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  sas_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output sas_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);
    import sas_pkg::*;

    logic      avg_valid, avg_stall;
    t_avg_pair avg;

    sas_accum #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_avg_valid (avg_valid),
        .o_avg       (avg),
        .i_avg_stall (avg_stall)
    );

    sas_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avg_valid (avg_valid),
        .i_avg       (avg),
        .o_avg_stall (avg_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: rtl/sas_checker.sv
// sas_checker: port-level checks on the sensor averaging block
// depends on sas_pkg; bound to sensor_average_and_scale
module sas_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input sas_pkg::t_in_item   i_in_item,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input sas_pkg::t_out_item  o_out_item,
    input logic                i_out_stall
);
    import sas_pkg::*;

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.pressure_tenths_kpa >= 10'd450 &&
                        o_out_item.pressure_tenths_kpa <= P_CLAMP)
        else $error("pressure out of range");

    a_tmag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.temperature_magnitude <= T_CLAMP)
        else $error("temperature magnitude out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not cleared by reset");

endmodule

bind sensor_average_and_scale sas_checker u_sas_checker (.*);

// File: verif/sas_reading_checker.sv
`timescale 1ns / 1ps
// sas_reading_checker: watches both channels of sensor_average_and_scale,
// predicts each converted reading from the accepted sample pairs and compares
// depends on sas_pkg
module sas_reading_checker #(
    parameter int SAMPLES_PER_AVERAGE = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  sas_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  sas_pkg::t_out_item  i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_pair_count,
    output int                  o_reading_count
);
    import sas_pkg::*;

    logic [SUM_W-1:0] pressure_acc;
    logic [SUM_W-1:0] temperature_acc;
    int               pairs_in_block;
    logic             held_negative;
    t_out_item        predicted_readings[$];
    t_out_item        oldest;
    int               fail_total;
    int               pair_total;
    int               reading_total;

    function automatic t_out_item scaled_reading(input logic [SUM_W-1:0] p_sum,
                                                 input logic [SUM_W-1:0] t_sum,
                                                 input logic neg_before);
        int unsigned p_avg;
        int unsigned t_avg;
        t_out_item   r;
        p_avg = p_sum / SAMPLES_PER_AVERAGE;
        t_avg = t_sum / SAMPLES_PER_AVERAGE;
        if (p_avg > ADC_LIMIT) begin
            r.pressure_tenths_kpa = P_CLAMP;
        end else begin
            r.pressure_tenths_kpa = PRES_W'(((p_avg + P_OFFSET) * P_MUL) / P_DIV);
        end
        if (t_avg > ADC_LIMIT) begin
            r.temperature_magnitude = T_CLAMP;
            r.temperature_negative  = neg_before;
        end else if (t_avg < T_SPLIT) begin
            r.temperature_magnitude = TMAG_W'(((T_SPLIT - t_avg) * T_MUL) / T_DIV);
            r.temperature_negative  = 1'b1;
        end else begin
            r.temperature_magnitude = TMAG_W'(((t_avg - T_SPLIT) * T_MUL) / T_DIV);
            r.temperature_negative  = 1'b0;
        end
        return r;
    endfunction

    initial begin
        fail_total    = 0;
        pair_total    = 0;
        reading_total = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pressure_acc    = '0;
            temperature_acc = '0;
            pairs_in_block  = 0;
            held_negative   = 1'b0;
            predicted_readings.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                reading_total++;
                if (predicted_readings.size() == 0) begin
                    $error("reading with no prediction waiting: %0d %0d %0d",
                           i_out_item.pressure_tenths_kpa,
                           i_out_item.temperature_magnitude,
                           i_out_item.temperature_negative);
                    fail_total++;
                end else begin
                    oldest = predicted_readings.pop_front();
                    if (i_out_item.pressure_tenths_kpa !== oldest.pressure_tenths_kpa) begin
                        $error("pressure_tenths_kpa expected %0d actual %0d",
                               oldest.pressure_tenths_kpa, i_out_item.pressure_tenths_kpa);
                        fail_total++;
                    end
                    if (i_out_item.temperature_magnitude !== oldest.temperature_magnitude) begin
                        $error("temperature_magnitude expected %0d actual %0d",
                               oldest.temperature_magnitude,
                               i_out_item.temperature_magnitude);
                        fail_total++;
                    end
                    if (i_out_item.temperature_negative !== oldest.temperature_negative) begin
                        $error("temperature_negative expected %0d actual %0d",
                               oldest.temperature_negative, i_out_item.temperature_negative);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pair_total++;
                pressure_acc    = pressure_acc + SUM_W'(i_in_item.pressure_sample);
                temperature_acc = temperature_acc + SUM_W'(i_in_item.temperature_sample);
                if (pairs_in_block + 1 < SAMPLES_PER_AVERAGE) begin
                    pairs_in_block++;
                end else begin
                    oldest = scaled_reading(pressure_acc, temperature_acc, held_negative);
                    held_negative = oldest.temperature_negative;
                    predicted_readings.push_back(oldest);
                    pressure_acc    = '0;
                    temperature_acc = '0;
                    pairs_in_block  = 0;
                end
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= predicted_readings.size();
        o_pair_count    <= pair_total;
        o_reading_count <= reading_total;
    end

endmodule

// File: verif/sensor_average_and_scale_tb.sv
`timescale 1ns / 1ps
// sensor_average_and_scale_tb: drives sample pairs and output stalls into the
// block under several idle mixes; verdict comes from sas_reading_checker
// depends on sas_pkg, sensor_average_and_scale, sas_reading_checker
module sensor_average_and_scale_tb;
    import sas_pkg::*;

    localparam int PAIRS_PER_BLOCK = 10;
    localparam int BLOCKS_PER_PHASE = 36;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_item;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       i_out_stall;

    int fail_count;
    int pending;
    int pair_count;
    int reading_count;

    int idle_pct;
    int stall_pct;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    int idle_mix[4]  = '{0, 55, 0, 33};
    int stall_mix[4] = '{0, 0, 55, 33};

    sensor_average_and_scale #(
        .SAMPLES_PER_AVERAGE(PAIRS_PER_BLOCK)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    sas_reading_checker #(
        .SAMPLES_PER_AVERAGE(PAIRS_PER_BLOCK)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_item       (i_in_item),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_item      (o_out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pair_count    (pair_count),
        .o_reading_count (reading_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // output side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_pair(input logic [SAMPLE_W-1:0] p, input logic [SAMPLE_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{pressure_sample: p, temperature_sample: t};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_level();
        case ($urandom_range(7))
            0:       return 0;
            1:       return T_SPLIT - 1;
            2:       return T_SPLIT;
            3:       return ADC_LIMIT;
            4:       return ADC_LIMIT + 1;
            5:       return SAMPLE_MAX;
            default: return $urandom_range(SAMPLE_MAX);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_near(input int unsigned level,
                                                        input int unsigned spread);
        int unsigned lo;
        int unsigned hi;
        lo = (level > spread) ? level - spread : 0;
        hi = (level + spread > SAMPLE_MAX) ? SAMPLE_MAX : level + spread;
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_block();
        int unsigned p_level;
        int unsigned t_level;
        int unsigned spread;
        p_level = pick_level();
        t_level = pick_level();
        case ($urandom_range(3))
            0, 1:    spread = 0;
            2:       spread = 24;
            default: spread = SAMPLE_MAX;
        endcase
        for (int k = 0; k < PAIRS_PER_BLOCK; k++) begin
            send_pair(sample_near(p_level, spread), sample_near(t_level, spread));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cold block below zero, then a clamped block that keeps the negative sign
        for (int k = 0; k < PAIRS_PER_BLOCK; k++) send_pair('0, '0);
        for (int k = 0; k < PAIRS_PER_BLOCK; k++) send_pair('1, '1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_mix[ph];
            stall_pct = stall_mix[ph];
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                if (ph == 0 && blk == 10) hold_request = 1'b1;
                send_block();
            end
            wait_drained();
        end

        // incomplete block gives no reading
        idle_pct  = 0;
        stall_pct = 0;
        for (int k = 0; k < PAIRS_PER_BLOCK / 2; k++) begin
            send_pair(sample_near(SAMPLE_MAX / 2, SAMPLE_MAX), sample_near(0, SAMPLE_MAX));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending != 0) $error("%0d predicted readings never arrived", pending);
        $display("sent %0d sample pairs, compared %0d converted readings", pair_count,
                 reading_count);
        $display("mixes: free flow, sender gaps, output stalls, both, plus a long hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
